FILE: src/srod_pkg.sv
// Package for the sector range obstacle detector.
// Holds request/result types, config register codes, controller states
// and the command/status bundles between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package srod_pkg;

    localparam int DEF_RANGE_BITS = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int SUM_W          = 32;
    localparam int DIV_STEPS      = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int NUM_SECTORS    = 3;
    localparam int CFG_ADDR_W     = 4;

    localparam logic [1:0] REG_RIGHT_EDGE = 2'd0;
    localparam logic [1:0] REG_LEFT_EDGE  = 2'd1;
    localparam logic [1:0] REG_WINDOW     = 2'd2;
    localparam logic [1:0] REG_THRESHOLD  = 2'd3;

    localparam logic [1:0] SECT_RIGHT = 2'd0;
    localparam logic [1:0] SECT_FRONT = 2'd1;
    localparam logic [1:0] SECT_LEFT  = 2'd2;

    localparam logic signed [15:0] RST_RIGHT_EDGE = -16'sd3000;
    localparam logic signed [15:0] RST_LEFT_EDGE  = 16'sd3000;
    localparam logic [15:0]        RST_WINDOW     = 16'd64;
    localparam logic [15:0]        RST_THRESHOLD  = 16'd1000;

    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] servo_angle;
    } in_t;

    typedef struct packed {
        logic               obstacle_right;
        logic               obstacle_front;
        logic               obstacle_left;
        logic [15:0]        average_right;
        logic [15:0]        average_front;
        logic [15:0]        average_left;
        logic [2:0]         empty_sectors;
        logic [15:0]        latest_range;
        logic signed [15:0] latest_angle;
    } out_t;

    typedef struct packed {
        logic signed [15:0] right_edge;
        logic signed [15:0] left_edge;
        logic [15:0]        window;
        logic [15:0]        threshold;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       accum;
        logic       div_load;
        logic       div_step;
        logic       div_save;
        logic       emit;
        logic [1:0] sect;
    } cmd_t;

    typedef struct packed {
        logic window_full;
        logic div_last;
        logic out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_SAVE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: src/srod_regs.sv
// Configuration register file behind the APB-style port.
// Depends on srod_pkg for register codes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module srod_regs
    import srod_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.right_edge <= RST_RIGHT_EDGE;
            cfg_reg.left_edge  <= RST_LEFT_EDGE;
            cfg_reg.window     <= RST_WINDOW;
            cfg_reg.threshold  <= RST_THRESHOLD;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_RIGHT_EDGE: cfg_reg.right_edge <= $signed(pwdata[15:0]);
                REG_LEFT_EDGE:  cfg_reg.left_edge  <= $signed(pwdata[15:0]);
                REG_WINDOW:     cfg_reg.window     <= pwdata[15:0];
                REG_THRESHOLD:  cfg_reg.threshold  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RIGHT_EDGE: prdata = {{16{cfg_reg.right_edge[15]}}, cfg_reg.right_edge};
            REG_LEFT_EDGE:  prdata = {{16{cfg_reg.left_edge[15]}}, cfg_reg.left_edge};
            REG_WINDOW:     prdata = {16'd0, cfg_reg.window};
            REG_THRESHOLD:  prdata = {16'd0, cfg_reg.threshold};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/srod_ctrl.sv
// Controller state machine: sequences accumulate, window check, three
// serial divisions and result hand-off. Depends on srod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srod_ctrl
    import srod_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t     state_reg, state_next;
    logic [1:0] sect_reg, sect_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sect_reg  <= SECT_RIGHT;
        end else begin
            state_reg <= state_next;
            sect_reg  <= sect_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sect_next  = sect_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.sect   = sect_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                sect_next = SECT_RIGHT;
                if (sts.window_full) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DIV_SAVE;
                end
            end
            ST_DIV_SAVE: begin
                cmd.div_save = 1'b1;
                if (sect_reg == SECT_LEFT) begin
                    state_next = ST_EMIT;
                end else begin
                    sect_next  = sect_reg + 2'd1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/srod_datapath.sv
// Datapath: sector accumulators, shared restoring divider, result register.
// Driven by srod_ctrl commands; depends on srod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srod_datapath
    import srod_pkg::*;
#(
    parameter int RANGE_BITS = DEF_RANGE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire in_t  in_data,
    input  wire cmd_t cmd,
    output sts_t      sts,
    input  wire logic m_ready,
    output logic      m_valid,
    output out_t      m_payload
);

    localparam int RB_USE = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam int TOT_W  = (COUNT_BITS + 2 > 16) ? COUNT_BITS + 2 : 16;

    logic [RB_USE-1:0]     range_reg;
    logic signed [15:0]    angle_reg;
    logic [1:0]            sel_reg;
    logic [SUM_W-1:0]      sum_reg [NUM_SECTORS];
    logic [COUNT_BITS-1:0] count_reg [NUM_SECTORS];
    logic [SUM_W-1:0]      quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] divisor_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [15:0]           avg_reg [NUM_SECTORS];
    logic [2:0]            flag_reg;
    logic [2:0]            empty_reg;
    logic                  m_valid_reg;
    out_t                  out_reg;

    logic [1:0]            sel_next;
    logic [SUM_W:0]        sum_add [NUM_SECTORS];
    logic [TOT_W-1:0]      total;
    logic [SUM_W-1:0]      div_sum;
    logic [COUNT_BITS-1:0] div_count;
    logic [COUNT_BITS:0]   rem_shift;
    logic [COUNT_BITS:0]   rem_diff;
    logic                  out_free;

    always_comb begin
        if ($signed(in_data.servo_angle) < $signed(cfg.right_edge)) begin
            sel_next = SECT_RIGHT;
        end else if ($signed(in_data.servo_angle) > $signed(cfg.left_edge)) begin
            sel_next = SECT_LEFT;
        end else begin
            sel_next = SECT_FRONT;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SECTORS; i++) begin
            sum_add[i] = {1'b0, sum_reg[i]} + (SUM_W + 1)'(range_reg);
        end
        total = TOT_W'(count_reg[0]) + TOT_W'(count_reg[1]) + TOT_W'(count_reg[2]);
    end

    always_comb begin
        case (cmd.sect)
            SECT_RIGHT: begin
                div_sum   = sum_reg[0];
                div_count = count_reg[0];
            end
            SECT_FRONT: begin
                div_sum   = sum_reg[1];
                div_count = count_reg[1];
            end
            SECT_LEFT: begin
                div_sum   = sum_reg[2];
                div_count = count_reg[2];
            end
            default: begin
                div_sum   = '0;
                div_count = '0;
            end
        endcase
    end

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign out_free  = !m_valid_reg || m_ready;

    assign sts.window_full = total >= TOT_W'(cfg.window);
    assign sts.div_last    = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign sts.out_free    = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            range_reg <= in_data.range_mm[RB_USE-1:0];
            angle_reg <= in_data.servo_angle;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else if (cmd.emit) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else if (cmd.accum) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                if (sel_reg == 2'(i)) begin
                    sum_reg[i] <= sum_add[i][SUM_W] ? '1 : sum_add[i][SUM_W-1:0];
                    if (count_reg[i] != '1) begin
                        count_reg[i] <= count_reg[i] + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg     <= div_sum;
            rem_reg     <= '0;
            divisor_reg <= div_count;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (!rem_diff[COUNT_BITS]) begin
                rem_reg <= rem_diff[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_save) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                if (cmd.sect == 2'(i)) begin
                    if (divisor_reg == '0) begin
                        avg_reg[i]   <= '0;
                        flag_reg[i]  <= 1'b0;
                        empty_reg[i] <= 1'b1;
                    end else begin
                        avg_reg[i]   <= quo_reg[15:0];
                        flag_reg[i]  <= (quo_reg <= SUM_W'(cfg.threshold));
                        empty_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.obstacle_right <= flag_reg[0];
            out_reg.obstacle_front <= flag_reg[1];
            out_reg.obstacle_left  <= flag_reg[2];
            out_reg.average_right  <= avg_reg[0];
            out_reg.average_front  <= avg_reg[1];
            out_reg.average_left   <= avg_reg[2];
            out_reg.empty_sectors  <= empty_reg;
            out_reg.latest_range   <= 16'(range_reg);
            out_reg.latest_angle   <= angle_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (total == '0))
        else $error("sector counts not cleared after result");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_save && (divisor_reg != '0)) |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.emit))
        else $error("result raised without emit command");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(out_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: src/sector_range_obstacle_detector.sv
// Top level of the sector range obstacle detector: config registers,
// controller and datapath. Depends on srod_pkg, srod_regs, srod_ctrl,
// srod_datapath.
//
//   port group   dir  handshake        payload
//   s_*          in   s_valid/s_ready  in_t  (range_mm, servo_angle)
//   m_*          out  m_valid/m_ready  out_t (flags, averages, empty, latest)
//   p*           in   APB write/read   4 x 16-bit registers at 4*i
//
// A request that does not close a window passes through accept, accumulate
// and window check. A closing request then runs one shared restoring
// divider, one quotient bit per cycle, for each of the three sectors in
// turn, and the result is emitted once the result register is free.
// Reset is synchronous, active low; it resets sums, counts, m_valid and config.
// A finished result waits in the output register while new requests are
// taken; the emit step holds only if a previous result is still pending.
`timescale 1ns / 1ps
`default_nettype none

module sector_range_obstacle_detector
    import srod_pkg::*;
#(
    parameter int RANGE_BITS = DEF_RANGE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_payload,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    srod_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srod_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srod_datapath #(
        .RANGE_BITS (RANGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_data   (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire
